// ===== hw/rtl/cce_pkg.sv =====
// Shared types, constants and tables for the cube case triangle emitter.
// No dependencies; imported by every module under hw/rtl.
`timescale 1ns / 1ps

package cce_pkg;

  localparam int NumRot   = 24;
  localparam int NumCases = 15;
  localparam int MaxTris  = 4;

  typedef logic [2:0] corner_t;
  typedef logic [4:0] rot_idx_t;
  typedef logic [3:0] case_sel_t;
  typedef logic [2:0] tri_cnt_t;
  typedef logic [1:0] tri_idx_t;

  // Decoded cube, held while its triangles are emitted.
  typedef struct packed {
    logic [7:0]        code;
    logic              known;
    case_sel_t         sel;
    tri_cnt_t          count;
    corner_t [7:0]     perm;   // perm[i]: physical corner of rotated corner i
    logic              flip;
  } job_t;

  // One emitted result.
  typedef struct packed {
    logic [7:0] code;
    logic       known;
    logic       tvalid;
    corner_t    v0a;
    corner_t    v0b;
    corner_t    v1a;
    corner_t    v1b;
    corner_t    v2a;
    corner_t    v2b;
    logic       last;
  } result_t;

  // Corner permutations, one hex digit per rotated corner, rotated corner 0 first.
  localparam logic [31:0] ROT_TABLE [NumRot] = '{
    32'h01234567, 32'h15620473, 32'h54761032, 32'h40375126,
    32'h45107623, 32'h32670145, 32'h30127456, 32'h04513762,
    32'h47650321, 32'h73264015, 32'h21563074, 32'h74036512,
    32'h23016745, 32'h37402651, 32'h76543210, 32'h62157304,
    32'h10452376, 32'h67325401, 32'h12305674, 32'h26731540,
    32'h65472103, 32'h51046237, 32'h03741265, 32'h56214730
  };

  localparam logic [7:0] CASE_CODE [NumCases] = '{
    8'd0, 8'd1, 8'd3, 8'd33, 8'd65, 8'd14, 8'd67, 8'd82,
    8'd15, 8'd141, 8'd85, 8'd77, 8'd30, 8'd165, 8'd142
  };

  localparam tri_cnt_t CASE_COUNT [NumCases] = '{
    3'd0, 3'd1, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3,
    3'd2, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
  };

  // Triangles in rotated corner positions: digits v0a v0b v1a v1b v2a v2b.
  localparam logic [23:0] CASE_TRIS [NumCases][MaxTris] = '{
    '{24'h000000, 24'h000000, 24'h000000, 24'h000000},
    '{24'h030401, 24'h000000, 24'h000000, 24'h000000},
    '{24'h030415, 24'h120315, 24'h000000, 24'h000000},
    '{24'h030401, 24'h565154, 24'h000000, 24'h000000},
    '{24'h030401, 24'h676265, 24'h000000, 24'h000000},
    '{24'h371526, 24'h373015, 24'h030115, 24'h000000},
    '{24'h030415, 24'h120315, 24'h676265, 24'h000000},
    '{24'h121015, 24'h474540, 24'h676265, 24'h000000},
    '{24'h042637, 24'h041526, 24'h000000, 24'h000000},
    '{24'h740467, 24'h040167, 24'h670162, 24'h620112},
    '{24'h010345, 24'h125623, 24'h034745, 24'h656723},
    '{24'h013704, 24'h370156, 24'h673765, 24'h011256},
    '{24'h011503, 24'h301537, 24'h152637, 24'h474504},
    '{24'h010304, 24'h262321, 24'h565154, 24'h747376},
    '{24'h014703, 24'h012647, 24'h742676, 24'h011526}
  };

endpackage

// ===== hw/rtl/cube_case_triangle_emitter_core.sv =====
// Top level of the cube case triangle emitter: input decode, held cube register,
// triangle emitter and result register. Depends on cce_pkg, cce_decode, cce_emit.
`timescale 1ns / 1ps

// A cube is transferred in on a rising edge with start high and busy low. Its
// results come out one per cycle on the result ports, each flagged by strobe
// for exactly one cycle; there is no back-pressure, so the receiver must take
// every result in the cycle it is shown. A cube gives one result per triangle
// (one to four), or a single empty result (triangle_valid low) when its code
// is zero or not a canonical case; last_of_cube marks the final one. The first
// result shows once the cube has passed the held cube register and the result
// register. The held cube register feeds a single emitter that produces one
// result per cycle; busy drops in the cycle the last result of the held cube
// is being formed, so the next cube can be taken in with no gap. Reset clears
// the control state only; there is no clearing pass.
module cube_case_triangle_emitter_core import cce_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] corner_flags,
  input  logic [4:0] rotation_index,
  input  logic       flip_winding,
  output logic       strobe,
  output logic [7:0] canonical_code,
  output logic       code_known,
  output logic       triangle_valid,
  output logic [2:0] v0_corner_a,
  output logic [2:0] v0_corner_b,
  output logic [2:0] v1_corner_a,
  output logic [2:0] v1_corner_b,
  output logic [2:0] v2_corner_a,
  output logic [2:0] v2_corner_b,
  output logic       last_of_cube
);

  job_t     dec;       // decode of the cube on the input ports
  job_t     job;       // cube whose triangles are being emitted
  logic     job_valid;
  tri_idx_t k;         // triangle index within the held cube
  result_t  res;       // result being formed this cycle
  result_t  res_q;     // result on the output ports
  logic     accept;

  cce_decode u_decode (
    .corner_flags   (corner_flags),
    .rotation_index (rotation_index),
    .flip_winding   (flip_winding),
    .job            (dec)
  );

  cce_emit u_emit (
    .job (job),
    .k   (k),
    .res (res)
  );

  // Free once the held cube is on its final result.
  assign busy   = job_valid && !res.last;
  assign accept = start && !busy;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      k         <= '0;
      strobe    <= 1'b0;
    end else begin
      strobe <= job_valid;
      if (accept) begin
        job_valid <= 1'b1;
        k         <= '0;
      end else if (job_valid && res.last) begin
        job_valid <= 1'b0;
        k         <= '0;
      end else if (job_valid) begin
        k <= k + 2'd1;
      end
    end
  end

  // Payload: held cube and output register
  always_ff @(posedge clk) begin
    if (accept) begin
      job <= dec;
    end
    if (job_valid) begin
      res_q <= res;
    end
  end

  assign canonical_code = res_q.code;
  assign code_known     = res_q.known;
  assign triangle_valid = res_q.tvalid;
  assign v0_corner_a    = res_q.v0a;
  assign v0_corner_b    = res_q.v0b;
  assign v1_corner_a    = res_q.v1a;
  assign v1_corner_b    = res_q.v1b;
  assign v2_corner_a    = res_q.v2a;
  assign v2_corner_b    = res_q.v2b;
  assign last_of_cube   = res_q.last;

  // Every cube transfer produces a result through the held cube and result registers.
  a_accept_to_result: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##2 strobe)
    else $error("no result after cube transfer");

  // An empty result ends its cube and carries no corners.
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && !triangle_valid) |-> (last_of_cube && v0_corner_a == '0 &&
      v1_corner_a == '0 && v2_corner_a == '0))
    else $error("malformed empty result");

  // Triangles only come from canonical cases.
  a_tri_known: assert property (@(posedge clk) disable iff (rst)
    (strobe && triangle_valid) |-> code_known)
    else $error("triangle from unknown case");

  // Triangle index stays inside the held case's triangle count.
  a_k_in_range: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (({1'b0, k} < job.count) || (job.count == '0 && k == '0)))
    else $error("triangle index beyond case count");

  // A result that is not the last is followed by another from the same cube.
  a_cube_continues: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_of_cube) |=> (strobe && $stable(canonical_code)))
    else $error("cube results broken off");

endmodule

// ===== hw/rtl/cce_decode.sv =====
// Cube decode: rotation lookup, rotated case code and canonical case match.
// Depends on cce_pkg.
`timescale 1ns / 1ps

module cce_decode import cce_pkg::*; (
  input  logic [7:0] corner_flags,
  input  logic [4:0] rotation_index,
  input  logic       flip_winding,
  output job_t       job
);

  rot_idx_t    ridx;
  logic [31:0] row;

  // indexes past the table fall back to the identity
  assign ridx = (rotation_index >= 5'(NumRot)) ? '0 : rotation_index;
  assign row  = ROT_TABLE[ridx];

  always_comb begin
    job      = '0;
    job.flip = flip_winding;
    for (int i = 0; i < 8; i++) begin
      job.perm[i]     = row[4*(7-i) +: 3];
      job.code[7 - i] = corner_flags[job.perm[i]];
    end
    for (int c = 0; c < NumCases; c++) begin
      if (job.code == CASE_CODE[c]) begin
        job.known = 1'b1;
        job.sel   = 4'(c);
        job.count = CASE_COUNT[c];
      end
    end
  end

endmodule

// ===== hw/rtl/cce_emit.sv =====
// Triangle emitter: picks triangle k of the held case, maps its rotated corners
// to physical corners and applies the winding swap. Depends on cce_pkg.
`timescale 1ns / 1ps

module cce_emit import cce_pkg::*; (
  input  job_t     job,
  input  tri_idx_t k,
  output result_t  res
);

  logic [23:0] tri_row;
  corner_t     c [6];
  logic        empty;

  assign tri_row = CASE_TRIS[job.sel][k];
  assign empty   = (job.count == '0);

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      c[j] = job.perm[tri_row[4*(5-j) +: 3]];
    end
  end

  always_comb begin
    res        = '0;
    res.code   = job.code;
    res.known  = job.known;
    if (empty) begin
      res.last = 1'b1;
    end else begin
      res.tvalid = 1'b1;
      res.last   = ({1'b0, k} == (job.count - 3'd1));
      if (job.flip) begin
        res.v0a = c[2];
        res.v0b = c[3];
        res.v1a = c[0];
        res.v1b = c[1];
      end else begin
        res.v0a = c[0];
        res.v0b = c[1];
        res.v1a = c[2];
        res.v1b = c[3];
      end
      res.v2a = c[4];
      res.v2b = c[5];
    end
  end

endmodule
